// ===== rtl/rhc_pkg.sv =====
// shared types and constants for the rgb / hsv colour converter
package rhc_pkg;

	localparam int CHAN_BITS = 16;

	typedef logic [CHAN_BITS-1:0] chan_t;

	typedef enum logic [1:0] {
		OP_TO_HSV = 2'd0,
		OP_TO_RGB = 2'd1,
		OP_ROTATE = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]                  op;
		chan_t                       chan_a;
		chan_t                       chan_b;
		chan_t                       chan_c;
		logic signed [CHAN_BITS-1:0] hue_shift;
	} cmd_t;

	typedef struct packed {
		chan_t res_a;
		chan_t res_b;
		chan_t res_c;
	} res_t;

endpackage

// ===== rtl/rgb_hsv_colour_converter.sv =====
// rgb / hsv hexcone colour converter, fully pipelined top level
//
// one command beat enters on start (busy is always low, so every start is
// taken); cmd.op picks rgb to hsv, hsv to rgb, or hue rotation of an rgb
// pixel by cmd.hue_shift turns. channels, saturation, value and hue are
// unsigned q0.16 fractions.
// the result beat appears on res with done high for one cycle; throughput
// is one beat per clock, and each beat runs through the two bit-per-stage
// dividers (saturation and hue) that run side by side, followed by the
// multiply and round stages of the hsv to rgb path.
// every beat is independent; op 3 yields an all-zero result.
// arst_n clears only the valid bits, so beats in flight are dropped and
// nothing comes out until new starts arrive.
// the receiver cannot stall: results are shown once and must be taken.
module rgb_hsv_colour_converter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rhc_pkg::cmd_t cmd,
	output logic          done,
	output rhc_pkg::res_t res
);

	localparam int C   = rhc_pkg::CHAN_BITS;
	localparam int QW  = C + 1;
	localparam int HDW = C + 3;
	localparam int SNW = C + QW;
	localparam int HNW = HDW + QW;
	localparam int LAT = C + 12;
	localparam logic [C-1:0] FULL    = '1;
	localparam logic [C-1:0] HALF    = C'(1 << (C - 1));
	localparam logic [C-1:0] HALF_M1 = C'((1 << (C - 1)) - 1);
	localparam logic [C:0]   TURN    = (C+1)'(1 << C);

	typedef enum logic [1:0] {MAX_R, MAX_G, MAX_B} maxsel_t;

	typedef struct packed {
		logic [1:0]    op;
		rhc_pkg::chan_t a;
		rhc_pkg::chan_t b;
		rhc_pkg::chan_t c;
		rhc_pkg::chan_t shift;
		rhc_pkg::chan_t mx;
		logic          flat;
	} side_t;

	typedef struct packed {
		logic [1:0]    op;
		rhc_pkg::res_t hsv;
		logic [2:0]    sect;
		logic          gray;
		rhc_pkg::chan_t vv;
	} tail_t;

	function automatic logic [C-1:0] div_full_est(input logic [2*C-1:0] y);
		logic [2*C:0] acc;
		acc = {1'b0, y} + (2*C+1)'(y >> C);
		return C'(acc >> C);
	endfunction

	function automatic logic [C-1:0] div_full_fix(input logic [2*C-1:0] y,
			input logic [C-1:0] est);
		logic [2*C:0] rem;
		rem = {1'b0, y} - (2*C+1)'({est, {C{1'b0}}}) + (2*C+1)'(est);
		return (rem >= (2*C+1)'(FULL)) ? est + C'(1) : est;
	endfunction

	assign busy = 1'b0;

	// stage 1: capture
	logic          vld_s1;
	rhc_pkg::cmd_t cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
	end

	// stage 2: max, min, range
	logic           vld_s2;
	rhc_pkg::cmd_t  cmd_s2;
	rhc_pkg::chan_t mx_s2;
	rhc_pkg::chan_t rng_s2;
	maxsel_t        sel_s2;
	rhc_pkg::chan_t mx_c;
	rhc_pkg::chan_t mn_c;
	maxsel_t        sel_c;

	always_comb begin
		priority if (cmd_s1.chan_a >= cmd_s1.chan_b && cmd_s1.chan_a >= cmd_s1.chan_c) begin
			mx_c  = cmd_s1.chan_a;
			sel_c = MAX_R;
		end else if (cmd_s1.chan_b >= cmd_s1.chan_c) begin
			mx_c  = cmd_s1.chan_b;
			sel_c = MAX_G;
		end else begin
			mx_c  = cmd_s1.chan_c;
			sel_c = MAX_B;
		end
		mn_c = cmd_s1.chan_a;
		if (cmd_s1.chan_b < mn_c) begin
			mn_c = cmd_s1.chan_b;
		end
		if (cmd_s1.chan_c < mn_c) begin
			mn_c = cmd_s1.chan_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s2 <= cmd_s1;
		mx_s2  <= mx_c;
		rng_s2 <= mx_c - mn_c;
		sel_s2 <= sel_c;
	end

	// stage 3: hue numerator in sextant units, saturation numerator
	logic           vld_s3;
	rhc_pkg::cmd_t  cmd_s3;
	rhc_pkg::chan_t mx_s3;
	logic           flat_s3;
	logic [HDW-1:0] n_s3;
	logic [HDW-1:0] den6_s3;
	logic [SNW-1:0] nums_s3;
	logic [HDW-1:0] r6_c;
	logic [HDW-1:0] wrap_c;
	logic [HDW-1:0] n_c;

	assign r6_c = HDW'({rng_s2, 2'b00}) + HDW'({rng_s2, 1'b0});

	always_comb begin
		wrap_c = r6_c + HDW'(cmd_s2.chan_b) - HDW'(cmd_s2.chan_c);
		unique case (sel_s2)
			MAX_R: begin
				n_c = (wrap_c >= r6_c) ? wrap_c - r6_c : wrap_c;
			end
			MAX_G: begin
				n_c = HDW'({rng_s2, 1'b0}) + HDW'(cmd_s2.chan_c) - HDW'(cmd_s2.chan_a);
			end
			MAX_B: begin
				n_c = HDW'({rng_s2, 2'b00}) + HDW'(cmd_s2.chan_a) - HDW'(cmd_s2.chan_b);
			end
			default: begin
				n_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s3  <= cmd_s2;
		mx_s3   <= mx_s2;
		flat_s3 <= rng_s2 == '0;
		n_s3    <= n_c;
		den6_s3 <= r6_c;
		nums_s3 <= SNW'({rng_s2, {C{1'b0}}}) - SNW'(rng_s2) + SNW'(mx_s2 >> 1);
	end

	// dividers
	logic [HNW-1:0] numh_c;
	logic [QW-1:0]  squo;
	logic [QW-1:0]  hquo;

	assign numh_c = HNW'({n_s3, {C{1'b0}}}) + HNW'(den6_s3 >> 1);

	rhc_div #(
		.DEN_W (C),
		.QUO_W (QW)
	) u_sat_div (
		.clk (clk),
		.num (nums_s3),
		.den (mx_s3),
		.quo (squo)
	);

	rhc_div #(
		.DEN_W (HDW),
		.QUO_W (QW)
	) u_hue_div (
		.clk (clk),
		.num (numh_c),
		.den (den6_s3),
		.quo (hquo)
	);

	logic [QW-1:0] dvld_s;
	side_t         dside_s [QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld_s <= '0;
		end else begin
			dvld_s <= {dvld_s[QW-2:0], vld_s3};
		end
	end

	always_ff @(posedge clk) begin
		dside_s[0] <= '{op: cmd_s3.op, a: cmd_s3.chan_a, b: cmd_s3.chan_b,
			c: cmd_s3.chan_c, shift: rhc_pkg::chan_t'(cmd_s3.hue_shift),
			mx: mx_s3, flat: flat_s3};
		for (int i = 1; i < QW; i++) begin
			dside_s[i] <= dside_s[i-1];
		end
	end

	// stage 4: hsv result, hsv operands for the rgb path
	side_t          dv;
	rhc_pkg::chan_t hue_c;
	rhc_pkg::chan_t sat_c;
	logic           vld_s4;
	logic [1:0]     op_s4;
	rhc_pkg::res_t  hsv_s4;
	rhc_pkg::chan_t hh_s4;
	rhc_pkg::chan_t ss_s4;
	rhc_pkg::chan_t vv_s4;

	assign dv    = dside_s[QW-1];
	assign hue_c = dv.flat ? '0 : hquo[C-1:0];
	assign sat_c = dv.flat ? '0 : squo[C-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= dvld_s[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		op_s4  <= dv.op;
		hsv_s4 <= '{res_a: hue_c, res_b: sat_c, res_c: dv.mx};
		if (dv.op == rhc_pkg::OP_TO_RGB) begin
			hh_s4 <= dv.a;
			ss_s4 <= dv.b;
			vv_s4 <= dv.c;
		end else begin
			hh_s4 <= hue_c + dv.shift;
			ss_s4 <= sat_c;
			vv_s4 <= dv.mx;
		end
	end

	// stage 5: sextant and fraction
	logic           vld_s5;
	tail_t          tl_s5;
	rhc_pkg::chan_t f_s5;
	rhc_pkg::chan_t ss_s5;
	rhc_pkg::chan_t ns_s5;
	logic [C+2:0]   h6_c;

	assign h6_c = (C+3)'({hh_s4, 2'b00}) + (C+3)'({hh_s4, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		tl_s5 <= '{op: op_s4, hsv: hsv_s4, sect: h6_c[C+2:C], gray: ss_s4 == '0,
			vv: vv_s4};
		f_s5  <= h6_c[C-1:0];
		ss_s5 <= ss_s4;
		ns_s5 <= FULL - ss_s4;
	end

	// stage 6: s * f and s * (1 - f)
	logic           vld_s6;
	tail_t          tl_s6;
	rhc_pkg::chan_t ns_s6;
	logic [2*C-1:0] pq_s6;
	logic [2*C:0]   pt_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		tl_s6 <= tl_s5;
		ns_s6 <= ns_s5;
		pq_s6 <= (2*C)'(ss_s5) * (2*C)'(f_s5);
		pt_s6 <= (2*C+1)'(ss_s5) * (2*C+1)'(TURN - (C+1)'(f_s5));
	end

	// stage 7: round and complement
	logic           vld_s7;
	tail_t          tl_s7;
	rhc_pkg::chan_t ns_s7;
	rhc_pkg::chan_t kq_s7;
	rhc_pkg::chan_t kt_s7;
	logic [2*C:0]   rq_c;
	logic [2*C:0]   rt_c;

	assign rq_c = (2*C+1)'(pq_s6) + (2*C+1)'(HALF);
	assign rt_c = pt_s6 + (2*C+1)'(HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		tl_s7 <= tl_s6;
		ns_s7 <= ns_s6;
		kq_s7 <= FULL - C'(rq_c >> C);
		kt_s7 <= FULL - C'(rt_c >> C);
	end

	// stage 8: scale by value
	logic           vld_s8;
	tail_t          tl_s8;
	logic [2*C-1:0] mp_s8;
	logic [2*C-1:0] mq_s8;
	logic [2*C-1:0] mt_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		tl_s8 <= tl_s7;
		mp_s8 <= (2*C)'(tl_s7.vv) * (2*C)'(ns_s7);
		mq_s8 <= (2*C)'(tl_s7.vv) * (2*C)'(kq_s7);
		mt_s8 <= (2*C)'(tl_s7.vv) * (2*C)'(kt_s7);
	end

	// stage 9: rounded divide by full scale, estimate
	logic           vld_s9;
	tail_t          tl_s9;
	logic [2*C-1:0] yp_s9;
	logic [2*C-1:0] yq_s9;
	logic [2*C-1:0] yt_s9;
	rhc_pkg::chan_t ep_s9;
	rhc_pkg::chan_t eq_s9;
	rhc_pkg::chan_t et_s9;
	logic [2*C-1:0] yp_c;
	logic [2*C-1:0] yq_c;
	logic [2*C-1:0] yt_c;

	assign yp_c = mp_s8 + (2*C)'(HALF_M1);
	assign yq_c = mq_s8 + (2*C)'(HALF_M1);
	assign yt_c = mt_s8 + (2*C)'(HALF_M1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		tl_s9 <= tl_s8;
		yp_s9 <= yp_c;
		yq_s9 <= yq_c;
		yt_s9 <= yt_c;
		ep_s9 <= div_full_est(yp_c);
		eq_s9 <= div_full_est(yq_c);
		et_s9 <= div_full_est(yt_c);
	end

	// stage 10: remainder correction
	logic           vld_s10;
	tail_t          tl_s10;
	rhc_pkg::chan_t p_s10;
	rhc_pkg::chan_t q_s10;
	rhc_pkg::chan_t t_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		tl_s10 <= tl_s9;
		p_s10  <= div_full_fix(yp_s9, ep_s9);
		q_s10  <= div_full_fix(yq_s9, eq_s9);
		t_s10  <= div_full_fix(yt_s9, et_s9);
	end

	// stage 11: sextant select and output
	logic          vld_s11;
	rhc_pkg::res_t res_s11;
	rhc_pkg::res_t rgb_c;
	rhc_pkg::res_t out_c;

	always_comb begin
		unique case (tl_s10.sect)
			3'd0:    rgb_c = '{res_a: tl_s10.vv, res_b: t_s10, res_c: p_s10};
			3'd1:    rgb_c = '{res_a: q_s10, res_b: tl_s10.vv, res_c: p_s10};
			3'd2:    rgb_c = '{res_a: p_s10, res_b: tl_s10.vv, res_c: t_s10};
			3'd3:    rgb_c = '{res_a: p_s10, res_b: q_s10, res_c: tl_s10.vv};
			3'd4:    rgb_c = '{res_a: t_s10, res_b: p_s10, res_c: tl_s10.vv};
			default: rgb_c = '{res_a: tl_s10.vv, res_b: p_s10, res_c: q_s10};
		endcase
		if (tl_s10.gray) begin
			rgb_c = '{res_a: tl_s10.vv, res_b: tl_s10.vv, res_c: tl_s10.vv};
		end
		unique case (tl_s10.op)
			rhc_pkg::OP_TO_HSV: out_c = tl_s10.hsv;
			rhc_pkg::OP_TO_RGB: out_c = rgb_c;
			rhc_pkg::OP_ROTATE: out_c = rgb_c;
			default:            out_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else begin
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		res_s11 <= out_c;
	end

	assign done = vld_s11;
	assign res  = res_s11;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("accepted beat did not come out after the pipeline latency");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result beat without a matching command beat");

	a_flat_hsv: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && cmd.op == rhc_pkg::OP_TO_HSV &&
			cmd.chan_a == cmd.chan_b && cmd.chan_b == cmd.chan_c, LAT)
		|-> res.res_a == '0 && res.res_b == '0 && res.res_c == $past(cmd.chan_a, LAT))
		else $error("gray pixel did not give zero hue and saturation");

	a_gray_rgb: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && cmd.op == rhc_pkg::OP_TO_RGB && cmd.chan_b == '0, LAT)
		|-> res.res_a == $past(cmd.chan_c, LAT) && res.res_b == $past(cmd.chan_c, LAT) &&
			res.res_c == $past(cmd.chan_c, LAT))
		else $error("zero saturation did not give value on every channel");

endmodule

// ===== rtl/rhc_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module rhc_div #(
	parameter int DEN_W = 16,
	parameter int QUO_W = 17
) (
	input  logic                   clk,
	input  logic [DEN_W+QUO_W-1:0] num,
	input  logic [DEN_W-1:0]       den,
	output logic [QUO_W-1:0]       quo
);

	localparam int NUM_W = DEN_W + QUO_W;

	logic [DEN_W-1:0] rem_s [QUO_W-1];
	logic [QUO_W-1:0] low_s [QUO_W-1];
	logic [DEN_W-1:0] den_s [QUO_W-1];
	logic [QUO_W-1:0] quo_s [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_step
		logic [DEN_W-1:0] rem_in;
		logic [QUO_W-1:0] low_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;
		logic [DEN_W:0]   trial;
		logic             fit;

		if (i == 0) begin : g_first
			assign rem_in = num[NUM_W-1:QUO_W];
			assign low_in = num[QUO_W-1:0];
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign low_in = low_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign trial = {rem_in, low_in[QUO_W-1]};
		assign fit   = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			quo_s[i] <= {quo_in[QUO_W-2:0], fit};
		end

		if (i < QUO_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[i] <= fit ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
				low_s[i] <= low_in << 1;
				den_s[i] <= den_in;
			end
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule
